// File: hw/rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, register map and mode codes of the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned SampleCountDef = 50;
  localparam int unsigned SumW           = 24;
  localparam int unsigned CfgAddrW       = 5;
  localparam int unsigned CfgDataW       = 64;

  // register indexes, one 8-byte slot each
  localparam logic [1:0] RegSamplePeriod = 2'd0;
  localparam logic [1:0] RegRecalPeriod  = 2'd1;
  localparam logic [1:0] RegMotionLimit  = 2'd2;

  localparam logic [23:0] SamplePeriodRst = 24'd10000;
  localparam logic [31:0] RecalPeriodRst  = 32'd60000000;
  localparam logic [35:0] MotionLimitRst  = 36'd2621;

  // calibration modes, also reported as phase
  localparam logic [1:0] ModeCollect = 2'd0;
  localparam logic [1:0] ModeAverage = 2'd1;
  localparam logic [1:0] ModeIdle    = 2'd2;

  typedef struct packed {
    logic [23:0] sample_period_us;
    logic [31:0] recal_period_us;
    logic [35:0] motion_limit_sq;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        time_us;
    logic               armed;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_y;
    logic signed [15:0] bias_z;
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [15:0] corr_z;
    logic [1:0]         phase;
    logic               cal_done;
    logic               cal_wanted;
  } out_item_t;

endpackage

// File: hw/rtl/gbc_apb_regs.sv
// ----------------------------------------------------------------------------
// gbc_apb_regs
// APB register file holding the pacing periods and the motion limit.
// ----------------------------------------------------------------------------
module gbc_apb_regs
  import gbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CfgAddrW-1:3];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period_us <= SamplePeriodRst;
      cfg_q.recal_period_us  <= RecalPeriodRst;
      cfg_q.motion_limit_sq  <= MotionLimitRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSamplePeriod: cfg_q.sample_period_us <= pwdata[23:0];
        RegRecalPeriod:  cfg_q.recal_period_us  <= pwdata[31:0];
        RegMotionLimit:  cfg_q.motion_limit_sq  <= pwdata[35:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSamplePeriod: prdata = {40'd0, cfg_q.sample_period_us};
      RegRecalPeriod:  prdata = {32'd0, cfg_q.recal_period_us};
      RegMotionLimit:  prdata = {28'd0, cfg_q.motion_limit_sq};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/gbc_motion.sv
// ----------------------------------------------------------------------------
// gbc_motion
// Squared distance of the accel vector from the still reference, vs. limit.
// ----------------------------------------------------------------------------
module gbc_motion
  import gbc_pkg::*;
(
  input  logic signed [15:0] still_ref_i [3],
  input  logic signed [15:0] acc_i       [3],
  input  logic        [35:0] limit_i,
  output logic               still_o
);

  logic signed [16:0] diff [3];
  logic signed [33:0] sq   [3];
  logic        [33:0] sq_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {still_ref_i[i][15], still_ref_i[i]} - {acc_i[i][15], acc_i[i]};
      sq[i]   = 34'(diff[i]) * 34'(diff[i]);
    end
    // each square is below 2^32, the sum below 2^34
    sq_sum = {2'b00, sq[0][31:0]} + {2'b00, sq[1][31:0]} + {2'b00, sq[2][31:0]};
  end

  assign still_o = {2'b00, sq_sum} < limit_i;

endmodule

// File: hw/rtl/gbc_avg.sv
// ----------------------------------------------------------------------------
// gbc_avg
// Rounded division of a rate sum by the sample count, clamped to 16 bits.
// ----------------------------------------------------------------------------
module gbc_avg
  import gbc_pkg::*;
#(
  parameter int unsigned SampleCount = SampleCountDef
) (
  input  logic signed [SumW-1:0] sum_i,
  output logic signed [15:0]     avg_o
);

  // exact floor(m / SampleCount) for any m below 2^SumW
  localparam int unsigned    ShL    = $clog2(SampleCount);
  localparam int unsigned    Sh     = SumW + ShL;
  localparam int unsigned    RecipW = SumW + 2;
  localparam longint unsigned Recip =
      ((64'd1 << Sh) + 64'(SampleCount) - 64'd1) / 64'(SampleCount);
  localparam int unsigned    Half   = SampleCount / 2;

  logic                     neg;
  logic [SumW-1:0]          mag;
  logic [SumW-1:0]          num;
  logic [SumW+RecipW-1:0]   prod;
  logic [SumW-1:0]          quo;
  logic signed [SumW:0]     quo_s;

  always_comb begin
    neg   = sum_i[SumW-1];
    mag   = neg ? SumW'(-sum_i) : SumW'(sum_i);
    num   = mag + SumW'(Half);
    prod  = (SumW+RecipW)'(num) * (SumW+RecipW)'(RecipW'(Recip));
    quo   = SumW'(prod >> Sh);
    // ties go away from zero since the magnitude is rounded
    quo_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (quo_s > (SumW+1)'(32767)) begin
      avg_o = 16'sh7fff;
    end else if (quo_s < -(SumW+1)'(32768)) begin
      avg_o = -16'sh8000;
    end else begin
      avg_o = quo_s[15:0];
    end
  end

endmodule

// File: hw/rtl/gbc_core.sv
// ----------------------------------------------------------------------------
// gbc_core
// Calibration state and its per-item update; builds the result item.
// ----------------------------------------------------------------------------
module gbc_core
  import gbc_pkg::*;
#(
  parameter int unsigned SampleCount = SampleCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  localparam int unsigned TallyW = $clog2(SampleCount + 1);

  logic [1:0]             mode_q, mode_d, mode_cur;
  logic [TallyW-1:0]      tally_q, tally_d;
  logic signed [SumW-1:0] sums_q [3];
  logic signed [SumW-1:0] sums_d [3];
  logic signed [15:0]     still_ref_q [3];
  logic signed [15:0]     still_ref_d [3];
  logic signed [15:0]     offs_q [3];
  logic signed [15:0]     offs_d [3];
  logic signed [15:0]     avg [3];
  logic [31:0]            stamp_q, stamp_d;
  logic                   recal_q, recal_d;
  logic                   done;

  logic signed [15:0] acc  [3];
  logic signed [15:0] gyro [3];
  logic signed [15:0] corr [3];
  logic signed [16:0] diff [3];
  logic [31:0]        elapsed;
  logic               sample_due;
  logic               recal_due;
  logic               still;

  assign acc[0]  = item_i.acc_x;
  assign acc[1]  = item_i.acc_y;
  assign acc[2]  = item_i.acc_z;
  assign gyro[0] = item_i.gyro_x;
  assign gyro[1] = item_i.gyro_y;
  assign gyro[2] = item_i.gyro_z;

  gbc_motion u_motion (
    .still_ref_i (still_ref_q),
    .acc_i       (acc),
    .limit_i     (cfg_i.motion_limit_sq),
    .still_o     (still)
  );

  for (genvar g = 0; g < 3; g++) begin : gen_avg
    gbc_avg #(
      .SampleCount (SampleCount)
    ) u_avg (
      .sum_i (sums_q[g]),
      .avg_o (avg[g])
    );
  end

  assign mode_cur   = (mode_q == ModeCollect || mode_q == ModeAverage) ? mode_q : ModeIdle;
  assign elapsed    = item_i.time_us - stamp_q;
  assign sample_due = elapsed >= {8'd0, cfg_i.sample_period_us};
  assign recal_due  = elapsed >= cfg_i.recal_period_us;

  always_comb begin
    mode_d      = mode_cur;
    tally_d     = tally_q;
    sums_d      = sums_q;
    still_ref_d = still_ref_q;
    offs_d      = offs_q;
    stamp_d     = stamp_q;
    recal_d     = recal_q;
    done        = 1'b0;

    unique case (mode_cur)
      ModeCollect: begin
        if (item_i.armed) begin
          mode_d = ModeIdle;
        end else if (sample_due) begin
          stamp_d = item_i.time_us;
          if (!still) begin
            // motion: restart from the new accel
            still_ref_d = acc;
            for (int i = 0; i < 3; i++) sums_d[i] = '0;
            tally_d = '0;
          end else if (tally_q < TallyW'(SampleCount)) begin
            for (int i = 0; i < 3; i++) begin
              sums_d[i] = sums_q[i] + SumW'(gyro[i]);
            end
            tally_d = tally_q + TallyW'(1);
          end else begin
            mode_d = ModeAverage;
          end
        end
      end
      ModeAverage: begin
        offs_d  = avg;
        mode_d  = ModeIdle;
        recal_d = 1'b0;
        done    = 1'b1;
      end
      default: begin
        if (item_i.armed) begin
          recal_d = 1'b1;
        end else begin
          if (recal_due) begin
            stamp_d = item_i.time_us;
          end
          if (recal_due || recal_q) begin
            recal_d     = 1'b1;
            mode_d      = ModeCollect;
            still_ref_d = acc;
            for (int i = 0; i < 3; i++) sums_d[i] = '0;
            tally_d = '0;
          end
        end
      end
    endcase
  end

  // corrected rate uses the offsets after this transaction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {gyro[i][15], gyro[i]} - {offs_d[i][15], offs_d[i]};
      if (diff[i][16] != diff[i][15]) begin
        corr[i] = diff[i][16] ? -16'sh8000 : 16'sh7fff;
      end else begin
        corr[i] = diff[i][15:0];
      end
    end
  end

  always_comb begin
    res_o.bias_x     = offs_d[0];
    res_o.bias_y     = offs_d[1];
    res_o.bias_z     = offs_d[2];
    res_o.corr_x     = corr[0];
    res_o.corr_y     = corr[1];
    res_o.corr_z     = corr[2];
    res_o.phase      = mode_d;
    res_o.cal_done   = done;
    res_o.cal_wanted = recal_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeCollect;
      tally_q <= '0;
      stamp_q <= '0;
      recal_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sums_q[i]      <= '0;
        still_ref_q[i] <= '0;
        offs_q[i]      <= '0;
      end
    end else if (fire_i) begin
      mode_q      <= mode_d;
      tally_q     <= tally_d;
      stamp_q     <= stamp_d;
      recal_q     <= recal_d;
      sums_q      <= sums_d;
      still_ref_q <= still_ref_d;
      offs_q      <= offs_d;
    end
  end

endmodule

// File: hw/rtl/gyro_bias_calibrator.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrator
// Gyroscope bias estimation while the vehicle is at rest.
// ----------------------------------------------------------------------------
// Takes one IMU update per transaction and returns one result transaction for
// each. Throughput is one transaction per clock while the output does not
// stall: an update is registered, run through the still test, the sum update
// or the constant divide combinationally, and the result lands in an output
// register. A stalled output holds the output register; the input side stalls
// when both registers are full and the output is stalled. While disarmed the
// block takes one paced sample per sample period, adds raw gyro to the sums
// while the accel stays within the motion limit of its start vector, and after
// SAMPLE_COUNT samples divides the sums into offsets. Arming or a quiet recal
// period raises cal_wanted. Registers sit at byte addresses 0, 8 and 16 of a
// 64-bit APB port; write them only while the block holds no transaction.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator
  import gbc_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT = SampleCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t res;
  logic      advance;
  logic      in_take;

  gbc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register moves on when the output register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  gbc_core #(
    .SampleCount (SAMPLE_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
